### rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion forms shared by the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every rising edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check on every rising edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/core/stbs_pkg.sv
// ---------------------------------------------------------------------------
// Sorted table search package
// Shared types and codes for the controller and the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package stbs_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = 8;
  localparam int KEY_IN_W    = 32;
  localparam int CNT_W       = 9;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 9;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COMPARE_SIGNED = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DONE
  } stbs_state_t;

  typedef struct packed {
    logic wr;
    logic start;
    logic step;
    logic out_load;
  } stbs_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic finish;
    logic out_full;
  } stbs_sts_t;

endpackage

`default_nettype wire

### rtl/core/sorted_table_binary_search.sv
// A write beat is accepted in IDLE; the next beat is accepted in the following cycle.
// A search has an intake step, the probe loop (floor(log2(count))+1 probes at
// most, 9 for 256 entries) and a hand-over step that waits while the output is full.
// The probe loop is set by one registered key table read per cycle.
// Reset (rst, synchronous) clears entry count, sign mode, state and output valid;
// table contents stay undefined until written.
// ---------------------------------------------------------------------------
// Sorted table binary search
// Loads a sorted key table and returns the match or insert position of a key.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sorted_table_binary_search #(
  parameter int KEY_WIDTH = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_wen,
  input  wire logic [stbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [stbs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [39:0]                     s_tdata,  // entry_index, key_value
  input  wire logic                            s_tuser,  // operation
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [23:0]                          m_tdata,  // match_index, insert_position
  output logic                                 m_tuser   // found
);
  import stbs_pkg::*;

  stbs_cmd_t        cmd;
  stbs_sts_t        sts;
  logic [IDX_W-1:0] out_match;
  logic [CNT_W-1:0] out_insert;

  stbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_op    (s_tuser),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  stbs_dpath #(
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_index   (s_tdata[IDX_W-1:0]),
    .in_key     (s_tdata[IDX_W+KEY_IN_W-1:IDX_W]),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .out_found  (m_tuser),
    .out_match  (out_match),
    .out_insert (out_insert)
  );

  assign m_tdata = {7'b0, out_insert, out_match};

  `ASSERT_CLK(a_load_free, cmd.out_load |-> (!m_tvalid || m_tready), "result beat overwritten")
  `ASSERT_CLK(a_search_busy, cmd.start |=> !s_tready, "beat accepted during search")
  `ASSERT_CLK(a_found_pos, m_tvalid && m_tuser |-> out_insert == CNT_W'(out_match), "bad insert")
  `ASSERT_CLK(a_miss_index, m_tvalid && !m_tuser |-> out_match == '0, "miss with nonzero index")

endmodule

`default_nettype wire

### rtl/core/stbs_ctrl.sv
// ---------------------------------------------------------------------------
// Sorted table search controller
// Sequences item intake, the probe loop and result hand-over.
// ---------------------------------------------------------------------------
`default_nettype none

module stbs_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic                in_op,
  output logic                     in_ready,
  input  wire stbs_pkg::stbs_sts_t sts,
  output stbs_pkg::stbs_cmd_t      cmd
);
  import stbs_pkg::*;

  stbs_state_t state;
  stbs_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op == OP_SEARCH) begin
            cmd.start  = 1'b1;
            state_next = sts.count_zero ? ST_DONE : ST_SEARCH;
          end else begin
            cmd.wr = 1'b1;
          end
        end
      end
      ST_SEARCH: begin
        cmd.step = 1'b1;
        if (sts.finish) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!sts.out_full) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/stbs_dpath.sv
// ---------------------------------------------------------------------------
// Sorted table search datapath
// Key table, configuration, probe range registers and result registers.
// ---------------------------------------------------------------------------
`default_nettype none

module stbs_dpath #(
  parameter int KEY_WIDTH = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire stbs_pkg::stbs_cmd_t             cmd,
  output stbs_pkg::stbs_sts_t                  sts,
  input  wire logic                            cfg_wen,
  input  wire logic [stbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [stbs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic [stbs_pkg::IDX_W-1:0]      in_index,
  input  wire logic [stbs_pkg::KEY_IN_W-1:0]   in_key,
  input  wire logic                            out_ready,
  output logic                                 out_valid,
  output logic                                 out_found,
  output logic [stbs_pkg::IDX_W-1:0]           out_match,
  output logic [stbs_pkg::CNT_W-1:0]           out_insert
);
  import stbs_pkg::*;

  localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [KEY_WIDTH-1:0] SIGN_BIT = KEY_WIDTH'(1) << (KEY_WIDTH - 1);

  logic [KEY_WIDTH-1:0] key_table [TABLE_DEPTH];
  logic [KEY_WIDTH-1:0] rdata;
  logic [ADDR_W-1:0]    rd_addr;
  logic                 wr_hit;

  logic [CNT_W-1:0]     count;
  logic                 csigned;
  logic [KEY_WIDTH-1:0] key;
  logic [CNT_W-1:0]     lo;
  logic [CNT_W-1:0]     hi1;
  logic [CNT_W-1:0]     mid;

  logic                 res_found;
  logic [IDX_W-1:0]     res_match;
  logic [CNT_W-1:0]     res_insert;

  logic [KEY_WIDTH-1:0] key_in;
  logic [KEY_WIDTH-1:0] flip;
  logic [KEY_WIDTH-1:0] cmp_a;
  logic [KEY_WIDTH-1:0] cmp_b;
  logic                 lt;
  logic                 gt;
  logic                 eq;
  logic [CNT_W-1:0]     lo_next;
  logic [CNT_W-1:0]     hi1_next;
  logic [CNT_W:0]       init_sum;
  logic [CNT_W-1:0]     init_mid;
  logic [CNT_W:0]       mid_sum;
  logic [CNT_W-1:0]     mid_next;
  logic [CNT_W-1:0]     count_sat;

  assign key_in = KEY_WIDTH'(in_key);
  assign wr_hit = cmd.wr && (32'(in_index) < TABLE_DEPTH);

  // compare on offset-binary when signed
  assign flip  = csigned ? SIGN_BIT : '0;
  assign cmp_a = key ^ flip;
  assign cmp_b = rdata ^ flip;
  assign lt    = cmp_a < cmp_b;
  assign gt    = cmp_a > cmp_b;
  assign eq    = !lt && !gt;

  assign lo_next  = gt ? (mid + CNT_W'(1)) : lo;
  assign hi1_next = lt ? mid : hi1;
  assign mid_sum  = {1'b0, lo_next} + {1'b0, hi1_next} - (CNT_W+1)'(1);
  assign mid_next = mid_sum[CNT_W:1];
  assign init_sum = {1'b0, count} - (CNT_W+1)'(1);
  assign init_mid = init_sum[CNT_W:1];

  assign rd_addr = cmd.start ? ADDR_W'(init_mid) : ADDR_W'(mid_next);

  assign count_sat = (32'(cfg_data) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH) : CNT_W'(cfg_data);

  assign sts.count_zero = (count == '0);
  assign sts.finish     = eq || (lo_next >= hi1_next);
  assign sts.out_full   = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (wr_hit) begin
      key_table[ADDR_W'(in_index)] <= key_in;
    end
    rdata <= key_table[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      csigned <= 1'b0;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_ENTRY_COUNT:    count   <= count_sat;
        REG_COMPARE_SIGNED: csigned <= cfg_data[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key <= key_in;
      lo  <= '0;
      hi1 <= count;
      mid <= init_mid;
      if (count == '0) begin
        res_found  <= 1'b0;
        res_match  <= '0;
        res_insert <= '0;
      end
    end else if (cmd.step) begin
      lo  <= lo_next;
      hi1 <= hi1_next;
      mid <= mid_next;
      if (sts.finish) begin
        res_found  <= eq;
        res_match  <= eq ? mid[IDX_W-1:0] : '0;
        res_insert <= eq ? mid : lo_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_found  <= res_found;
      out_match  <= res_match;
      out_insert <= res_insert;
    end
  end

endmodule

`default_nettype wire

### tb/tb_sorted_table_binary_search.sv
// ---------------------------------------------------------------------------
// Sorted table binary search testbench
// Loads ascending key tables through the input stream and searches them in
// both compare modes. A scoreboard keeps its own copy of the table and the
// register settings, computes the match or insert position of every search
// beat and checks each result beat against the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

import stbs_pkg::*;

typedef struct {
  bit       found;
  bit [7:0] match_index;
  bit [8:0] insert_position;
} search_result_t;

class search_scoreboard;
  bit [31:0]      key_table [256];
  int             entry_count;
  bit             compare_signed;
  search_result_t expected_q [$];
  int             errors;

  function void write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
    if (index == REG_ENTRY_COUNT) begin
      entry_count = (value > 9'd256) ? 256 : int'(value);
    end else if (index == REG_COMPARE_SIGNED) begin
      compare_signed = value[0];
    end
  endfunction

  function void note_beat(logic op, logic [7:0] index, logic [31:0] key);
    bit [31:0]      flip;
    bit [31:0]      probe;
    int             lo;
    int             hi;
    int             mid;
    search_result_t res;
    if (op == OP_WRITE) begin
      key_table[index] = key;
      return;
    end
    flip = compare_signed ? 32'h8000_0000 : 32'h0;
    res  = '{found: 1'b0, match_index: 8'd0, insert_position: 9'd0};
    lo   = 0;
    hi   = entry_count - 1;
    while (lo <= hi) begin
      mid   = (lo + hi) / 2;
      probe = key_table[mid] ^ flip;
      if ((key ^ flip) < probe) begin
        hi = mid - 1;
      end else if ((key ^ flip) > probe) begin
        lo = mid + 1;
      end else begin
        res.found           = 1'b1;
        res.match_index     = mid[7:0];
        res.insert_position = mid[8:0];
        break;
      end
    end
    if (!res.found) begin
      res.insert_position = lo[8:0];
    end
    expected_q.push_back(res);
  endfunction

  function void check_result(logic found, logic [7:0] match_index, logic [8:0] insert_position);
    search_result_t exp_res;
    if (expected_q.size() == 0) begin
      $error("result beat with no search pending");
      errors++;
      return;
    end
    exp_res = expected_q.pop_front();
    if (found !== exp_res.found) begin
      $error("found: expected %0d, got %0d", exp_res.found, found);
      errors++;
    end
    if (match_index !== exp_res.match_index) begin
      $error("match_index: expected %0d, got %0d", exp_res.match_index, match_index);
      errors++;
    end
    if (insert_position !== exp_res.insert_position) begin
      $error("insert_position: expected %0d, got %0d", exp_res.insert_position,
             insert_position);
      errors++;
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tb_sorted_table_binary_search;

  localparam int ITEM_TARGET = 1900;
  localparam int CYCLE_LIMIT = 400000;
  localparam int IDLE_GUARD  = 16;
  localparam int HOLD_CYCLES = 400;

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  cfg_wen   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [39:0]           s_tdata   = '0;  // entry_index, key_value
  logic                  s_tuser   = 1'b0;  // operation
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [23:0]           m_tdata;  // match_index, insert_position
  logic                  m_tuser;  // found

  search_scoreboard table_sb = new();

  int items_sent    = 0;
  int searches_sent = 0;
  int results_seen  = 0;
  int phases_run    = 0;
  int cycle_count   = 0;
  bit tx_steady     = 1'b0;
  bit rx_steady     = 1'b0;
  bit hold_req      = 1'b0;

  sorted_table_binary_search dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_beat(logic op, logic [7:0] index, logic [31:0] key);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 10);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {key, index};
    do @(posedge clk); while (!s_tready);
    table_sb.note_beat(op, index, key);
    items_sent++;
    if (op == OP_SEARCH) begin
      searches_sent++;
    end
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    table_sb.write_register(index, value);
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  // drop valid, drain all pending results, then let a trailing write settle
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (table_sb.pending() != 0) @(posedge clk);
    repeat (IDLE_GUARD) @(posedge clk);
  endtask

  task automatic run_phase(logic [8:0] count_raw, bit sign_mode, int n_search);
    bit [31:0] vals [$];
    bit [31:0] flip;
    bit [31:0] base;
    bit [31:0] key;
    int        eff;
    int        pick;
    int        span_mode;
    eff       = (count_raw > 9'd256) ? 256 : int'(count_raw);
    flip      = sign_mode ? 32'h8000_0000 : 32'h0;
    span_mode = $urandom_range(0, 1);
    base      = $urandom;
    wait_idle();
    set_reg(REG_ENTRY_COUNT, count_raw);
    set_reg(REG_COMPARE_SIGNED, {8'd0, sign_mode});
    for (int i = 0; i < eff; i++) begin
      key = (span_mode == 0) ? $urandom : base + $urandom_range(0, eff);
      vals.push_back(key ^ flip);
    end
    vals.sort();
    foreach (vals[i]) begin
      vals[i] = vals[i] ^ flip;
      send_beat(OP_WRITE, i[7:0], vals[i]);
    end
    if (eff < 256) begin
      repeat ($urandom_range(0, 3)) send_beat(OP_WRITE, 8'($urandom_range(eff, 255)), $urandom);
    end
    for (int n = 0; n < n_search; n++) begin
      pick = $urandom_range(0, 9);
      if (eff == 0 && pick <= 6) begin
        pick = 8;
      end
      case (pick)
        0, 1, 2, 3, 4: begin
          send_beat(OP_SEARCH, 8'($urandom), vals[$urandom_range(0, eff - 1)]);
        end
        5, 6: begin
          key = vals[$urandom_range(0, eff - 1)];
          send_beat(OP_SEARCH, 8'($urandom), $urandom_range(0, 1) ? key + 1 : key - 1);
        end
        7: begin
          case ($urandom_range(0, 3))
            0: key = 32'h0000_0000;
            1: key = 32'hFFFF_FFFF;
            2: key = 32'h8000_0000;
            default: key = 32'h7FFF_FFFF;
          endcase
          send_beat(OP_SEARCH, 8'($urandom), key);
        end
        8: begin
          send_beat(OP_SEARCH, 8'($urandom), $urandom);
        end
        default: begin
          // overwrite a live entry: the table may fall out of order
          if (eff > 0) begin
            send_beat(OP_WRITE, 8'($urandom_range(0, eff - 1)), $urandom);
          end else begin
            send_beat(OP_SEARCH, 8'($urandom), $urandom);
          end
        end
      endcase
    end
    phases_run++;
  endtask

  initial begin : receiver
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = rx_steady ? 0 : $urandom_range(0, 10);
      if (hold_req) begin
        gap      = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      @(negedge clk);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      table_sb.check_result(m_tuser, m_tdata[7:0], m_tdata[16:8]);
      results_seen++;
    end
  end

  initial begin : stimulus
    logic [8:0] count_raw;
    int         phase_no;
    int         n_search;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    wait_idle();

    // empty table
    set_reg(REG_ENTRY_COUNT, 9'd0);
    set_reg(REG_COMPARE_SIGNED, 9'd0);
    send_beat(OP_SEARCH, 8'h00, 32'h0000_0000);
    send_beat(OP_SEARCH, 8'hFF, 32'hFFFF_FFFF);

    // extremes, ordered unsigned
    send_beat(OP_WRITE, 8'd0, 32'h0000_0000);
    send_beat(OP_WRITE, 8'd1, 32'h7FFF_FFFF);
    send_beat(OP_WRITE, 8'd2, 32'h8000_0000);
    send_beat(OP_WRITE, 8'd3, 32'hFFFF_FFFF);
    wait_idle();
    set_reg(REG_ENTRY_COUNT, 9'd4);
    send_beat(OP_SEARCH, 8'd0, 32'h0000_0000);
    send_beat(OP_SEARCH, 8'd0, 32'hFFFF_FFFF);
    send_beat(OP_SEARCH, 8'd0, 32'h7FFF_FFFF);
    send_beat(OP_SEARCH, 8'd0, 32'h8000_0000);
    send_beat(OP_SEARCH, 8'd0, 32'h4000_0000);
    send_beat(OP_SEARCH, 8'd0, 32'hC000_0000);

    // same table seen signed is out of order
    wait_idle();
    set_reg(REG_COMPARE_SIGNED, 9'd1);
    send_beat(OP_SEARCH, 8'd0, 32'h8000_0000);
    send_beat(OP_SEARCH, 8'd0, 32'h0000_0001);

    // extremes, ordered signed
    send_beat(OP_WRITE, 8'd0, 32'h8000_0000);
    send_beat(OP_WRITE, 8'd1, 32'hFFFF_FFFF);
    send_beat(OP_WRITE, 8'd2, 32'h0000_0000);
    send_beat(OP_WRITE, 8'd3, 32'h7FFF_FFFF);
    send_beat(OP_SEARCH, 8'd0, 32'h8000_0000);
    send_beat(OP_SEARCH, 8'd0, 32'h7FFF_FFFF);
    send_beat(OP_SEARCH, 8'd0, 32'hFFFF_FFFE);

    // single entry
    wait_idle();
    set_reg(REG_ENTRY_COUNT, 9'd1);
    send_beat(OP_SEARCH, 8'd0, 32'h8000_0000);
    send_beat(OP_SEARCH, 8'd0, 32'h7FFF_FFFF);

    phase_no = 0;
    while (items_sent < ITEM_TARGET) begin
      if (phase_no == 0) begin
        count_raw = 9'd511;
      end else if (phase_no % 15 == 7) begin
        count_raw = $urandom_range(0, 1) ? 9'd256 : 9'($urandom_range(257, 510));
      end else if ($urandom_range(0, 7) == 0) begin
        count_raw = 9'($urandom_range(0, 1));
      end else begin
        count_raw = 9'($urandom_range(2, 40));
      end
      n_search  = $urandom_range(10, 30);
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      if (phase_no == 3) begin
        // back-pressure: hold the result side while the input keeps streaming
        count_raw = 9'd24;
        n_search  = 40;
        tx_steady = 1'b1;
        hold_req  = 1'b1;
      end
      run_phase(count_raw, 1'($urandom_range(0, 1)), n_search);
      phase_no++;
    end

    wait_idle();
    $display("Sent %0d beats (%0d searches) over %0d random table settings;",
             items_sent, searches_sent, phases_run);
    $display("checked %0d results in both compare modes.", results_seen);
    if (table_sb.errors == 0 && table_sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
